// File: rtl/pll_divider_search_core_defines.svh
// Assertion macros for the PLL divider search core.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef PLL_DIVIDER_SEARCH_CORE_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PDS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold at the clock edge that follows a trigger.
`define PDS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/pds_pkg.sv
// Package for the PLL divider search core: constants, payload and control types.
// No dependencies; used by the divider, the window check and the top level.
`default_nettype none

package pds_pkg;

	localparam int EXT_W = 27;
	localparam int TGT_W = 29;
	localparam int M_W = 7;
	localparam int N_W = 9;
	localparam int PC_W = 2;
	localparam int P_NUM = 4;
	localparam int PV_W = 4;
	localparam int DVD_W = 36;
	localparam int DVS_W = 6;
	localparam int BND_W = 33;

	localparam logic [EXT_W-1:0] INTERNAL_HZ = EXT_W'(16000000);
	localparam logic [M_W-1:0] M_FIRST = M_W'(2);
	localparam logic [M_W-1:0] M_LAST = M_W'(63);
	localparam logic [N_W-1:0] N_LOW = N_W'(50);
	localparam logic [N_W-1:0] N_HIGH = N_W'(432);
	localparam logic [DVD_W-1:0] REF_LOW = DVD_W'(1000000);
	localparam logic [DVD_W-1:0] REF_HIGH = DVD_W'(2000000);
	localparam logic [DVD_W-1:0] VCO_LOW = DVD_W'(50000000);
	localparam logic [DVD_W-1:0] VCO_HIGH = DVD_W'(432000000);

	typedef struct packed {
		logic use_external;
		logic [EXT_W-1:0] external_freq;
		logic [TGT_W-1:0] target_freq;
	} req_item_t;

	typedef struct packed {
		logic [M_W-1:0] div_m;
		logic [N_W-1:0] mult_n;
		logic [PC_W-1:0] div_p_code;
		logic found;
	} rsp_item_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DVD_W-1:0] quotient;
		logic [DVS_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic hit;
		logic [PC_W-1:0] code;
	} win_rsp_t;

	typedef logic [P_NUM-1:0][BND_W-1:0] bnd_arr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_PFD_START,
		ST_PFD_WAIT,
		ST_VCO_START,
		ST_VCO_WAIT,
		ST_TRIAL,
		ST_NEXT_M,
		ST_FINISH
	} state_t;

	function automatic logic [PV_W-1:0] p_value(input logic [PC_W-1:0] code);
		logic [PV_W-1:0] v;
		case (code)
			2'd0: v = PV_W'(2);
			2'd1: v = PV_W'(4);
			2'd2: v = PV_W'(6);
			default: v = PV_W'(8);
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/pds_divider.sv
// Restoring radix-2 divider shared by the search sequencer, one quotient bit per cycle.
// Depends on pds_pkg for widths and the request and response structs.
`default_nettype none

module pds_divider (
	input  logic clk,
	input  logic arst_n,
	input  pds_pkg::div_req_t req,
	output pds_pkg::div_rsp_t rsp
);
	import pds_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: rtl/pds_window.sv
// Output window check: finds the first P whose scaled target bounds contain the VCO value.
// Depends on pds_pkg for the bound array and result types.
`default_nettype none

module pds_window (
	input  logic [pds_pkg::DVD_W-1:0] vco,
	input  pds_pkg::bnd_arr_t lo,
	input  pds_pkg::bnd_arr_t hi,
	input  logic tzero,
	output pds_pkg::win_rsp_t rsp
);
	import pds_pkg::*;

	always_comb begin
		rsp.hit = 1'b0;
		rsp.code = '0;
		for (int k = P_NUM - 1; k >= 0; k--) begin
			if (vco >= DVD_W'(lo[k]) && vco < DVD_W'(hi[k])) begin
				rsp.hit = !tzero;
				rsp.code = PC_W'(k);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pll_divider_search_core.sv
// PLL divider search core: request and response channels, search sequencer.
// A usable M runs the shared divider twice (reference/M, reference*432/M), others once.
// One request is in work at a time; a finished result waits in an output register.
// Reset clears the sequencer and the response valid; the datapath registers are not reset.
// Depends on pds_pkg, pds_divider, pds_window and pll_divider_search_core_defines.svh.
`default_nettype none

`include "pll_divider_search_core_defines.svh"

module pll_divider_search_core (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  pds_pkg::req_item_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output pds_pkg::rsp_item_t rsp_data
);
	import pds_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [PC_W-1:0] k_q;
	logic rsp_valid_q;
	rsp_item_t rsp_data_q;

	logic [EXT_W-1:0] ref_q;
	logic [TGT_W-1:0] tlo_q;
	logic [TGT_W:0] thi_q;
	logic tzero_q;
	bnd_arr_t lo_q;
	bnd_arr_t hi_q;
	logic [M_W-1:0] m_q;
	logic [N_W-1:0] n_q;
	logic [EXT_W-1:0] pfd_q;
	logic [DVS_W-1:0] prem_q;
	logic [DVD_W-1:0] vco_q;
	logic [DVS_W-1:0] vrem_q;
	logic fin_found_q;
	logic [PC_W-1:0] fin_code_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	win_rsp_t win;

	logic [PV_W-1:0] pv;
	logic [BND_W-1:0] prod_lo;
	logic [BND_W-1:0] prod_hi;
	logic n_low;
	logic vco_lo;
	logic vco_hi;
	logic borrow;
	logic [DVS_W-1:0] vrem_step;
	logic [DVD_W-1:0] vco_step;
	logic rsp_free;

	pds_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	pds_window u_window (
		.vco(vco_q),
		.lo(lo_q),
		.hi(hi_q),
		.tzero(tzero_q),
		.rsp(win)
	);

	assign pv = p_value(k_q);
	assign prod_lo = BND_W'(pv) * BND_W'(tlo_q);
	assign prod_hi = BND_W'(pv) * BND_W'(thi_q);

	assign n_low = n_q < N_LOW;
	assign vco_lo = vco_q < VCO_LOW;
	assign vco_hi = vco_q > VCO_HIGH;

	// Stepping N down by one subtracts reference/M from the running quotient.
	assign borrow = vrem_q < prem_q;
	assign vrem_step = borrow
		? DVS_W'({1'b0, vrem_q} + m_q - {1'b0, prem_q})
		: DVS_W'({1'b0, vrem_q} - {1'b0, prem_q});
	assign vco_step = vco_q - DVD_W'(pfd_q) - DVD_W'(borrow);

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) begin
				k_q <= k_q + PC_W'(1);
			end else begin
				k_q <= '0;
			end
			if (state_q == ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		div_req.start = 1'b0;
		div_req.dividend = DVD_W'(ref_q);
		div_req.divisor = m_q[DVS_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (k_q == PC_W'(P_NUM - 1)) begin
					state_d = ST_PFD_START;
				end
			end
			ST_PFD_START: begin
				div_req.start = 1'b1;
				state_d = ST_PFD_WAIT;
			end
			ST_PFD_WAIT: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient < REF_LOW) begin
						state_d = ST_FINISH;
					end else if (div_rsp.quotient > REF_HIGH) begin
						state_d = ST_NEXT_M;
					end else begin
						state_d = ST_VCO_START;
					end
				end
			end
			ST_VCO_START: begin
				div_req.start = 1'b1;
				div_req.dividend = DVD_W'(ref_q) * DVD_W'(N_HIGH);
				state_d = ST_VCO_WAIT;
			end
			ST_VCO_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				if (n_low || vco_lo) begin
					state_d = ST_NEXT_M;
				end else if (!vco_hi && win.hit) begin
					state_d = ST_FINISH;
				end
			end
			ST_NEXT_M: begin
				if (m_q == M_LAST) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_PFD_START;
				end
			end
			ST_FINISH: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ref_q <= req_data.use_external ? req_data.external_freq : INTERNAL_HZ;
					tlo_q <= req_data.target_freq - TGT_W'(1);
					thi_q <= {1'b0, req_data.target_freq} + (TGT_W + 1)'(2);
					tzero_q <= req_data.target_freq == '0;
					m_q <= M_FIRST;
					n_q <= N_HIGH;
					fin_found_q <= 1'b0;
					fin_code_q <= '0;
				end
			end
			ST_PREP: begin
				lo_q[k_q] <= prod_lo;
				hi_q[k_q] <= prod_hi;
			end
			ST_PFD_WAIT: begin
				if (div_rsp.done) begin
					pfd_q <= div_rsp.quotient[EXT_W-1:0];
					prem_q <= div_rsp.remainder;
				end
			end
			ST_VCO_WAIT: begin
				if (div_rsp.done) begin
					vco_q <= div_rsp.quotient;
					vrem_q <= div_rsp.remainder;
				end
			end
			ST_TRIAL: begin
				if (!(n_low || vco_lo)) begin
					if (!vco_hi && win.hit) begin
						fin_found_q <= 1'b1;
						fin_code_q <= win.code;
					end else begin
						n_q <= n_q - N_W'(1);
						vco_q <= vco_step;
						vrem_q <= vrem_step;
					end
				end
			end
			ST_NEXT_M: begin
				m_q <= m_q + M_W'(1);
				n_q <= N_HIGH;
			end
			ST_FINISH: begin
				if (rsp_free) begin
					rsp_data_q.div_m <= m_q;
					rsp_data_q.mult_n <= n_q;
					rsp_data_q.div_p_code <= fin_code_q;
					rsp_data_q.found <= fin_found_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

	`PDS_ASSERT(a_found_in_range, !(rsp_valid && rsp_data.found) || (rsp_data.div_m <= M_LAST && rsp_data.mult_n >= N_LOW), "found result with M or N out of range")
	`PDS_ASSERT(a_trial_rem_below_m, state_q != ST_TRIAL || {1'b0, vrem_q} < m_q, "running remainder not below M")
	`PDS_ASSERT(a_rsp_from_finish, !$rose(rsp_valid_q) || $past(state_q) == ST_FINISH, "response raised outside the finish state")
	`PDS_ASSERT_NEXT(a_rsp_drop, rsp_valid_q && !rsp_stall && state_q != ST_FINISH, !rsp_valid_q, "response held after transfer")

endmodule

`default_nettype wire
